/* hdl/lcgdsp_pkg.sv */
// Shared types, constants and controller/datapath command words for the sample picker.
package lcgdsp_pkg;

  localparam int RANGE_CAPACITY_DEF = 1024;
  localparam int MAX_PICKS_DEF      = 64;

  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_INC    = 32'd12345;
  localparam logic [15:0] HALF_MASK  = 16'hFFFF;
  localparam int          HALF_SHIFT = 16;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_SEED = 3'd0;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;

  typedef struct packed {
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic [6:0]         pick_count;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] picked_value;
    logic               is_last;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic err_range;
    logic err_count;
    logic clr_init;
    logic clr_step;
    logic gen_step;
    logic div_init;
    logic div_step;
    logic probe_init;
    logic probe_adv;
    logic mark;
    logic scan_init;
    logic rd_scan;
    logic scan_adv;
    logic scan_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic count_bad;
    logic clr_last;
    logic div_last;
    logic slot_free;
    logic marks_done;
    logic out_last;
    logic taken;
  } sts_t;

endpackage

/* hdl/lcg_distinct_sample_picker_unit.sv */
// Top level of the distinct sample picker: controller, datapath and ports.
//
// A request word (range_min, range_max, pick_count) enters on the in_ channel when
// in_valid is high and in_stall is low. The block then returns pick_count words
// on the out_ channel, the distinct picked values in ascending order, with is_last
// on the final one; a bad range or count returns one error word instead.
// One request is handled at a time; in_stall stays high until the last word leaves.
// Steps: a check state after the accept (an error word is valid right after it),
// a pass clearing the occupancy map slot by slot, per draw a generator step plus a
// one-bit-per-cycle modulo and a map read and check per probe, then a read and
// check per scanned slot and an output state per word, which waits on out_stall.
// The occupancy map RAM and the serial modulo set the time these steps take.
// When the receiver holds out_stall, the word stays on out_word and the scan waits.
// Reset (rst_n low, synchronous) clears the seed and generator to zero and idles
// the block; the map needs no clearing pass since every request clears it.
// The seed register at cfg byte address 0 is written over the APB-style port and
// reloads the generator; write it only while the block is idle.
module lcg_distinct_sample_picker_unit #(
  parameter int RANGE_CAPACITY = lcgdsp_pkg::RANGE_CAPACITY_DEF,
  parameter int MAX_PICKS      = lcgdsp_pkg::MAX_PICKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lcgdsp_pkg::in_word_t          in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lcgdsp_pkg::out_word_t         out_word,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lcgdsp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import lcgdsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_pready = 1'b1;

  lcgdsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcgdsp_dp #(
    .RANGE_CAPACITY (RANGE_CAPACITY),
    .MAX_PICKS      (MAX_PICKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cmd         (cmd),
    .sts         (sts)
  );
endmodule

/* hdl/lcgdsp_ram.sv */
// Generic simple dual-port RAM with registered read.
module lcgdsp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/lcgdsp_ctrl.sv */
// Controller state machine sequencing check, clear, draw, probe and ordered scan.
module lcgdsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcgdsp_pkg::sts_t   sts,
  output lcgdsp_pkg::cmd_t   cmd
);
  import lcgdsp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_PINIT = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;
  localparam logic [3:0] S_PCHK  = 4'd8;
  localparam logic [3:0] S_MARK  = 4'd9;
  localparam logic [3:0] S_SRD   = 4'd10;
  localparam logic [3:0] S_SCHK  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.range_bad) begin
          cmd.err_range = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.count_bad) begin
          cmd.err_count = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.clr_init = 1'b1;
          state_nxt    = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.gen_step = 1'b1;
        state_nxt    = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_PINIT;
      end
      S_PINIT: begin
        cmd.probe_init = 1'b1;
        state_nxt      = S_PRD;
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (sts.slot_free) begin
          state_nxt = S_MARK;
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = S_PRD;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.marks_done) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SRD;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_SRD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCHK;
      end
      S_SCHK: begin
        if (sts.slot_free) begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SRD;
        end else begin
          cmd.out_load = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.taken) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
            state_nxt     = S_SRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* hdl/lcgdsp_dp.sv */
// Datapath: generator, bit-serial modulo, probe pointer, occupancy map and output register.
module lcgdsp_dp #(
  parameter int RANGE_CAPACITY = lcgdsp_pkg::RANGE_CAPACITY_DEF,
  parameter int MAX_PICKS      = lcgdsp_pkg::MAX_PICKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lcgdsp_pkg::in_word_t              in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lcgdsp_pkg::out_word_t             out_word,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lcgdsp_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  input  lcgdsp_pkg::cmd_t                  cmd,
  output lcgdsp_pkg::sts_t                  sts
);
  import lcgdsp_pkg::*;

  localparam int SW = $clog2(RANGE_CAPACITY + 1);
  localparam int AW = $clog2(RANGE_CAPACITY);
  localparam logic signed [33:0] CAP34 = 34'(RANGE_CAPACITY);
  localparam logic [6:0] MAXP = 7'(MAX_PICKS);

  logic signed [31:0] min_r, max_r;
  logic [6:0]         count_r, n_r, k_r;
  logic [SW-1:0]      size_r, idx_r, p_r, pos_r, j_r, rem_r;
  logic [1:0]         ph_r;
  logic [31:0]        seed_r, gen_r, dvd_r;
  logic [4:0]         dcnt_r;
  logic               ovld_r;
  out_word_t          out_r;

  logic signed [33:0] span;
  logic               cfg_wr, ram_we, ram_wd, ram_rd;
  logic [SW:0]        rem_sh, psum, pbase_ext, size_ext;
  logic [SW-1:0]      pbase, padv;
  logic [1:0]         pstep;
  logic [AW-1:0]      ram_wa, ram_ra;

  assign span = 34'(max_r) - 34'(min_r) + 34'sd1;
  assign sts.range_bad  = (span <= 34'sd0) || (span > CAP34);
  assign sts.count_bad  = (count_r == 7'd0) || (count_r > MAXP) ||
                          (34'(count_r) > span);
  assign sts.clr_last   = (idx_r == size_r - SW'(1));
  assign sts.div_last   = (dcnt_r == 5'd31);
  assign sts.slot_free  = ~ram_rd;
  assign sts.marks_done = (n_r + 7'd1 == count_r);
  assign sts.out_last   = out_r.is_last;
  assign sts.taken      = ovld_r & ~out_stall;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr[2] == REG_SEED[2]);
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED[2]) ? seed_r : 32'd0;

  // bit-serial remainder step
  assign size_ext = {1'b0, size_r};
  assign rem_sh   = {rem_r, dvd_r[31]};

  // next probe slot, wrapped modulo the range size
  always_comb begin
    pbase = p_r;
    pstep = 2'd1;
    case (ph_r)
      2'd0: pbase = pos_r;
      2'd1: begin
        if (j_r == size_r - SW'(1)) pbase = pos_r;
        else pstep = 2'd2;
      end
      default: pbase = p_r;
    endcase
    pbase_ext = {1'b0, pbase};
    psum      = pbase_ext + (SW + 1)'(pstep);
    if (psum >= size_ext) psum = psum - size_ext;
    padv = psum[SW-1:0];
  end

  assign ram_we = cmd.clr_step | cmd.mark;
  assign ram_wd = cmd.mark;
  assign ram_wa = cmd.mark ? p_r[AW-1:0] : idx_r[AW-1:0];
  assign ram_ra = cmd.rd_scan ? idx_r[AW-1:0] : p_r[AW-1:0];

  lcgdsp_ram #(.WIDTH(1), .DEPTH(RANGE_CAPACITY)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
      gen_r  <= 32'd0;
      ovld_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        seed_r <= cfg_pwdata;
        gen_r  <= cfg_pwdata;
      end else if (cmd.gen_step) begin
        gen_r <= gen_r * LCG_MUL + LCG_INC;
      end
      if (cmd.err_range | cmd.err_count | cmd.out_load) ovld_r <= 1'b1;
      else if (sts.taken) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      min_r   <= in_word.range_min;
      max_r   <= in_word.range_max;
      count_r <= in_word.pick_count;
    end
    if (cmd.clr_init) begin
      size_r <= span[SW-1:0];
      idx_r  <= '0;
      n_r    <= '0;
    end
    if (cmd.clr_step) idx_r <= idx_r + SW'(1);
    if (cmd.div_init) begin
      dvd_r  <= {gen_r[15:0], gen_r[31:HALF_SHIFT] & HALF_MASK};
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r  <= {dvd_r[30:0], 1'b0};
      dcnt_r <= dcnt_r + 5'd1;
      if (rem_sh >= size_ext) rem_r <= SW'(rem_sh - size_ext);
      else rem_r <= rem_sh[SW-1:0];
    end
    if (cmd.probe_init) begin
      p_r   <= rem_r;
      pos_r <= rem_r;
      ph_r  <= 2'd0;
      j_r   <= '0;
    end
    if (cmd.probe_adv) begin
      p_r <= padv;
      case (ph_r)
        2'd0: begin
          ph_r <= 2'd1;
          j_r  <= '0;
        end
        2'd1: begin
          if (j_r == size_r - SW'(1)) ph_r <= 2'd2;
          else j_r <= j_r + SW'(1);
        end
        default: j_r <= j_r + SW'(1);
      endcase
    end
    if (cmd.mark) n_r <= n_r + 7'd1;
    if (cmd.scan_init) begin
      idx_r <= '0;
      k_r   <= '0;
    end
    if (cmd.scan_adv) idx_r <= idx_r + SW'(1);
    if (cmd.scan_next) begin
      idx_r <= idx_r + SW'(1);
      k_r   <= k_r + 7'd1;
    end
    if (cmd.err_range) begin
      out_r <= '{picked_value: 32'sd0, is_last: 1'b1, status: ST_BAD_RANGE};
    end else if (cmd.err_count) begin
      out_r <= '{picked_value: 32'sd0, is_last: 1'b1, status: ST_BAD_COUNT};
    end else if (cmd.out_load) begin
      out_r.picked_value <= min_r + $signed(32'(idx_r));
      out_r.is_last      <= (k_r + 7'd1 == count_r);
      out_r.status       <= ST_OK;
    end
  end

  assign out_valid = ovld_r;
  assign out_word  = out_r;
endmodule

/* bench/lcgdsp_checker.sv */
// Checker for the sample picker: predicts picks from each request and compares results.
`timescale 1ns / 1ps
module lcgdsp_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  lcgdsp_pkg::in_word_t  in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  lcgdsp_pkg::out_word_t out_word,
  input  logic                  seed_wr,
  input  logic [31:0]           seed_data,
  output int                    fail_count,
  output int                    pending_picks,
  output int                    pick_words_seen,
  output int                    error_words_seen
);
  import lcgdsp_pkg::*;

  out_word_t picks_q[$];
  logic [31:0] gen_state;
  bit taken_map[RANGE_CAPACITY_DEF];

  function automatic logic [31:0] draw_step();
    gen_state = gen_state * LCG_MUL + LCG_INC;
    return {gen_state[15:0], gen_state[31:16]};
  endfunction

  function automatic int unsigned slot_for(int unsigned pos, int unsigned size);
    int unsigned p;
    if (!taken_map[pos]) return pos;
    for (longint unsigned j = 1; j < 2 * size; j += 2) begin
      p = 32'((pos + j) % size);
      if (!taken_map[p]) return p;
    end
    for (int unsigned j = 1; j < size; j++) begin
      p = (pos + j) % size;
      if (!taken_map[p]) return p;
    end
    return pos;
  endfunction

  task automatic predict_picks(in_word_t w);
    longint span;
    int unsigned size;
    int unsigned cnt;
    int k;
    out_word_t o;
    span = longint'(w.range_max) - longint'(w.range_min) + 1;
    cnt = w.pick_count;
    if (span <= 0 || span > RANGE_CAPACITY_DEF) begin
      o = '{picked_value: 0, is_last: 1'b1, status: ST_BAD_RANGE};
      picks_q.push_back(o);
      return;
    end
    size = 32'(span);
    if (cnt == 0 || cnt > MAX_PICKS_DEF || cnt > size) begin
      o = '{picked_value: 0, is_last: 1'b1, status: ST_BAD_COUNT};
      picks_q.push_back(o);
      return;
    end
    foreach (taken_map[i]) taken_map[i] = 0;
    for (int n = 0; n < cnt; n++) taken_map[slot_for(draw_step() % size, size)] = 1;
    k = 0;
    for (int unsigned i = 0; i < size && k < cnt; i++) begin
      if (taken_map[i]) begin
        o.picked_value = w.range_min + i;
        o.is_last = (k + 1 == cnt);
        o.status = ST_OK;
        picks_q.push_back(o);
        k++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      gen_state = '0;
      fail_count <= 0;
      pending_picks <= 0;
      pick_words_seen <= 0;
      error_words_seen <= 0;
      picks_q.delete();
    end else begin
      if (seed_wr) gen_state = seed_data;
      if (in_valid && !in_stall) predict_picks(in_word);
      if (out_valid && !out_stall) begin
        if (out_word.status == ST_OK) pick_words_seen <= pick_words_seen + 1;
        else error_words_seen <= error_words_seen + 1;
        if (picks_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = picks_q.pop_front();
          if (exp_w.picked_value !== out_word.picked_value ||
              exp_w.is_last !== out_word.is_last || exp_w.status !== out_word.status) begin
            $display("%0t: mismatch expected value=%0d last=%0d status=%0d",
                     $time, exp_w.picked_value, exp_w.is_last, exp_w.status);
            $display("%0t:          actual value=%0d last=%0d status=%0d",
                     $time, out_word.picked_value, out_word.is_last, out_word.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_picks <= picks_q.size();
    end
  end

endmodule

/* bench/tb_lcg_distinct_sample_picker_unit.sv */
// Testbench top for the sample picker: reset, seed writes, requests and verdict.
`timescale 1ns / 1ps
module tb_lcg_distinct_sample_picker_unit;
  import lcgdsp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_word_t out_word;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, pending_picks, pick_words_seen, error_words_seen;
  longint cycle_count = 0;
  bit hold_off = 1'b0;
  int stall_left = 0;

  localparam longint CYCLE_LIMIT = 10_000_000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lcg_distinct_sample_picker_unit i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  lcgdsp_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .seed_wr(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == REG_SEED),
    .seed_data(cfg_pwdata), .fail_count, .pending_picks, .pick_words_seen,
    .error_words_seen
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stall per word, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        stall_left = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
        out_stall <= (stall_left != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= (stall_left != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_seed(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= REG_SEED; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Keep in_valid high into the next word when no gap is drawn.
  task automatic send_request(logic signed [31:0] lo, logic signed [31:0] hi, logic [6:0] cnt);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{range_min: lo, range_max: hi, pick_count: cnt};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_picks != 0);
    repeat (3000) @(posedge clk);
  endtask

  task automatic random_request();
    logic signed [31:0] lo;
    int unsigned size;
    int unsigned mode;
    mode = $urandom_range(0, 19);
    lo = $urandom;
    if (mode < 15) begin
      size = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 80);
      if (lo > 32'sh7FFFFFFF - 1024) lo = lo - 2048;
      send_request(lo, lo + size - 1,
                   7'($urandom_range(1, (size < 64) ? size : 64)));
    end else if (mode < 17) begin
      send_request(lo, lo + $urandom_range(0, 40), 7'($urandom));
    end else begin
      send_request($urandom, $urandom, 7'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: errors, extremes, even ranges forcing linear probing
    send_request(32'sd5, 32'sd4, 7'd1);
    send_request(32'sh7FFFFFFF, 32'sh80000000, 7'd1);
    send_request(32'sh80000000, 32'sh7FFFFFFF, 7'd1);
    send_request(32'sd0, 32'sd1024, 7'd1);
    send_request(32'sd0, 32'sd1023, 7'd0);
    send_request(32'sd0, 32'sd1023, 7'd65);
    send_request(32'sd0, 32'sd1023, 7'd127);
    send_request(32'sd0, 32'sd9, 7'd11);
    send_request(32'sd7, 32'sd7, 7'd1);
    send_request(32'sh80000000, 32'sh80000000 + 63, 7'd64);
    send_request(32'sh7FFFFFFF - 63, 32'sh7FFFFFFF, 7'd64);
    send_request(-32'sd4, 32'sd3, 7'd8);
    send_request(32'sd0, 32'sd1, 7'd2);
    send_request(32'sd100, 32'sd1123, 7'd64);
    send_request(-32'sd512, 32'sd511, 7'd33);
    drain();
    write_seed(32'hFFFFFFFF);
    send_request(32'sd0, 32'sd15, 7'd16);
    send_request(32'sd0, 32'sd2, 7'd3);
    drain();
    write_seed(32'h0);
    send_request(32'sd0, 32'sd63, 7'd64);
    // long receiver hold-off, counted from the first held word, while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        wait (out_valid);
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin repeat (3) random_request(); end
    join
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_seed($urandom);
      for (int n = 0; n < 40; n++) random_request();
    end
    drain();
    $display("Covered %0d pick words and %0d error words over six seed writes",
             pick_words_seen, error_words_seen);
    $display("and one long output hold-off that backed up the request side");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* lcg_distinct_sample_picker_unit.f */
hdl/lcgdsp_pkg.sv
hdl/lcgdsp_ram.sv
hdl/lcgdsp_ctrl.sv
hdl/lcgdsp_dp.sv
hdl/lcg_distinct_sample_picker_unit.sv
bench/lcgdsp_checker.sv
bench/tb_lcg_distinct_sample_picker_unit.sv
